/* src/lhc_pkg.sv */
// Shared types and constants for the LRU handle cache.
package lhc_pkg;

  localparam int CFG_W    = 7;
  localparam int ICON_W   = 32;
  localparam int SIZE_W   = 3;
  localparam int STAMP_W  = 32;
  localparam int HANDLE_W = 64;
  localparam int SLOT_W   = 6;
  localparam int KEY_W    = ICON_W + SIZE_W;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [ICON_W-1:0]   icon_index;
    logic [SIZE_W-1:0]   size_class;
    logic [STAMP_W-1:0]  frame_number;
    logic [HANDLE_W-1:0] fill_handle;
  } lhc_in_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
  } lhc_out_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic decide;
    logic publish;
  } lhc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_blocked;
  } lhc_sts_t;

endpackage

/* src/lhc_ctrl.sv */
// Controller state machine that sequences capture, scan, decision and result.
module lhc_ctrl
  import lhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  lhc_sts_t sts,
  output lhc_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_DECIDE  = 2'd2;
  localparam logic [1:0] ST_PUBLISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (!sts.out_blocked) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

/* src/lhc_datapath.sv */
// Datapath: entry memories, scan counter, match and oldest-stamp search, result register.
module lhc_datapath
  import lhc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  lhc_in_t          in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  lhc_cmd_t         cmd,
  output lhc_sts_t         sts,
  output logic             out_valid,
  input  logic             out_stall,
  output lhc_out_t         out_data
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int VCW = $clog2(ENTRIES + 1);
  localparam int CW  = ((VCW > CFG_W) ? VCW : CFG_W) + 1;

  logic [CFG_W-1:0]    cap;
  logic [VCW-1:0]      valid_count;
  lhc_in_t             req;
  logic [VCW-1:0]      cnt;
  logic                pend;
  logic [AW-1:0]       pend_idx;
  logic                found;
  logic [AW-1:0]       found_idx;
  logic [STAMP_W-1:0]  best_stamp;
  logic [AW-1:0]       best_idx;
  logic                res_hit;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_evicted;

  logic [KEY_W-1:0]    key_mem    [ENTRIES];
  logic [STAMP_W-1:0]  stamp_mem  [ENTRIES];
  logic [HANDLE_W-1:0] handle_mem [ENTRIES];
  logic [KEY_W-1:0]    key_rd;
  logic [STAMP_W-1:0]  stamp_rd;
  logic [HANDLE_W-1:0] handle_rd;

  logic          cnt_live;
  logic [CW-1:0] cap_w;
  logic [CW-1:0] eff_cap;
  logic          evict;
  logic          fill_ok;
  logic [AW-1:0] target;
  logic [AW-1:0] wr_idx;
  logic          stamp_we;
  logic          fill_we;

  assign cnt_live = (cnt < valid_count);

  // Capacity clamped to the range one through ENTRIES.
  assign cap_w = CW'(cap);
  always_comb begin
    if (cap == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign evict    = (CW'(valid_count) >= eff_cap);
  assign fill_ok  = (req.fill_handle != '0);
  assign target   = evict ? best_idx : valid_count[AW-1:0];
  assign wr_idx   = found ? found_idx : target;
  assign stamp_we = cmd.decide && (found || fill_ok);
  assign fill_we  = cmd.decide && !found && fill_ok;

  assign sts.scan_done   = !cnt_live && !pend;
  assign sts.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.scan && cnt_live) begin
      key_rd   <= key_mem[cnt[AW-1:0]];
      stamp_rd <= stamp_mem[cnt[AW-1:0]];
    end
    if (cmd.decide) begin
      handle_rd <= handle_mem[found_idx];
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= req.frame_number;
    end
    if (fill_we) begin
      key_mem[wr_idx]    <= {req.size_class, req.icon_index};
      handle_mem[wr_idx] <= req.fill_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= CAP_RESET;
      valid_count <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.capture) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= cnt_live;
      end
      if (fill_we && !evict) begin
        valid_count <= valid_count + VCW'(1);
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req        <= in_data;
      cnt        <= '0;
      found      <= 1'b0;
      found_idx  <= '0;
      best_stamp <= '1;
      best_idx   <= '0;
    end else if (cmd.scan) begin
      pend_idx <= cnt[AW-1:0];
      if (cnt_live) begin
        cnt <= cnt + VCW'(1);
      end
      if (pend) begin
        if (!found && key_rd == {req.size_class, req.icon_index}) begin
          found     <= 1'b1;
          found_idx <= pend_idx;
        end
        if (stamp_rd < best_stamp) begin
          best_stamp <= stamp_rd;
          best_idx   <= pend_idx;
        end
      end
    end
    if (cmd.decide) begin
      res_hit     <= found;
      res_evicted <= !found && fill_ok && evict;
      res_handle  <= fill_ok ? req.fill_handle : '0;
      res_slot    <= (found || fill_ok) ? SLOT_W'(wr_idx) : '0;
    end
    if (cmd.publish) begin
      out_data.hit     <= res_hit;
      out_data.handle  <= res_hit ? handle_rd : res_handle;
      out_data.slot    <= res_slot;
      out_data.evicted <= res_evicted;
    end
  end

endmodule

/* src/lru_handle_cache_unit.sv */
// Top level of the fully associative LRU handle cache.
//
// Each input beat on in_data is one lookup: a key (icon index and size
// class), the current frame number and the handle to store on a miss.
// Every lookup yields exactly one result beat on out_data, carrying the hit
// flag, the handle, the entry slot and whether an older entry was evicted.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The single capacity register is written through cfg_we and
// cfg_wdata, and is meant to be written only while no lookup is in flight.
// Each lookup passes through capture, the scan, a decision and publication
// before the next lookup is accepted. The scan reads one entry per cycle from
// the key and stamp memories, searching for a match and for the oldest stamp
// in one pass, and then drains its read register. A new lookup is taken while
// the last result waits in the output register; only when the output register
// is still held by a stalled receiver does the next result wait in its final
// step. Reset empties the cache at once (the count of valid entries goes to
// zero) and sets the capacity to 64.
module lru_handle_cache_unit
  import lhc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lhc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lhc_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  lhc_cmd_t cmd;
  lhc_sts_t sts;

  // The controller walks each lookup through capture, scan, decide and publish.
  lhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the entry memories, the search and the output register.
  lhc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // An accepted lookup holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("lookup accepted without the block going busy");

  // A hit never reports an eviction.
  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("result flags both hit and evicted");

  // A failed fill reports slot zero.
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit && out_data.handle == '0) |->
      (out_data.slot == '0 && !out_data.evicted))
    else $error("failed fill reported a written slot");

  // The controller never issues two of its commands together.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.scan, cmd.decide, cmd.publish}))
    else $error("controller issued overlapping commands");
`endif

endmodule

/* tb/sv/lru_handle_cache_unit_test.sv */
// Self-checking testbench for the LRU handle cache: directed table, then random lookups.
module lru_handle_cache_unit_test;
  import lhc_pkg::*;

  localparam int NUM_ENTRIES = 64;
  // Keys that random lookups reuse, so hits and evictions happen often.
  localparam int KEY_POOL = 96;
  // Cycles let pass after the last result before a capacity write, and at the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT = 80;
  // The limit covers a lookup with a full cache, the longest sender gap
  // and receiver stall, and plenty of margin on top of that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 122;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lhc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lhc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  lru_handle_cache_unit #(
    .ENTRIES(NUM_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the cache contents. Only entries below used_entries are
  // ever read, exactly as in the hardware.
  logic [ICON_W-1:0] cache_icon[NUM_ENTRIES];
  logic [SIZE_W-1:0] cache_size[NUM_ENTRIES];
  logic [STAMP_W-1:0] cache_stamp[NUM_ENTRIES];
  logic [HANDLE_W-1:0] cache_handle[NUM_ENTRIES];
  int used_entries = 0;
  logic [CFG_W-1:0] capacity_reg = CAP_RESET;

  // Results still owed by the block, oldest first.
  lhc_out_t expected_results[$];
  int mismatches = 0;

  // Largest idle gap that the sender and the receiver draw from for each beat.
  // A value of zero gives a stretch with no idling at all.
  int gap_max = 8;
  int stall_max = 8;

  // Random keys come from this pool, and the recency stamps follow a frame
  // counter that mostly creeps forward, so that equal stamps show up too.
  logic [ICON_W-1:0] pool_icon[KEY_POOL];
  logic [SIZE_W-1:0] pool_size[KEY_POOL];
  logic [STAMP_W-1:0] frame_now = '0;

  // One row of the directed table: either a capacity write or a lookup. A
  // lookup with a typed-in answer uses it; any other lookup uses the predictor.
  typedef struct {
    bit is_cap;
    logic [CFG_W-1:0] cap;
    lhc_in_t req;
    bit known;
    lhc_out_t want;
  } step_t;

  step_t plan[$];

  // The register may hold anything from 0 to 127. Zero behaves as one entry,
  // and anything above the entry count behaves as the full cache.
  function automatic int effective_capacity();
    int cap;
    cap = int'(capacity_reg);
    if (cap < 1) cap = 1;
    if (cap > NUM_ENTRIES) cap = NUM_ENTRIES;
    return cap;
  endfunction

  // Predicts the answer to one lookup and updates the shadow cache. The
  // lowest matching entry answers a hit and gets its stamp refreshed. A miss
  // with a zero fill handle stores nothing. Any other miss appends while
  // there is room below the capacity, and otherwise replaces the entry with
  // the smallest stamp, where the lowest index wins a tie.
  function automatic lhc_out_t cache_lookup(lhc_in_t req);
    lhc_out_t res;
    int target;
    logic [STAMP_W-1:0] oldest_stamp;
    res = '0;
    for (int i = 0; i < used_entries; i++) begin
      if (cache_icon[i] == req.icon_index && cache_size[i] == req.size_class) begin
        cache_stamp[i] = req.frame_number;
        res.hit = 1'b1;
        res.handle = cache_handle[i];
        res.slot = SLOT_W'(i);
        return res;
      end
    end
    if (req.fill_handle == '0) return res;
    if (used_entries >= effective_capacity()) begin
      // The search starts from the largest stamp and keeps only strictly
      // smaller ones, so entry 0 wins when every stamp is all ones.
      target = 0;
      oldest_stamp = '1;
      for (int i = 0; i < used_entries; i++) begin
        if (cache_stamp[i] < oldest_stamp) begin
          oldest_stamp = cache_stamp[i];
          target = i;
        end
      end
      res.evicted = 1'b1;
    end else begin
      target = used_entries;
      used_entries++;
    end
    cache_icon[target] = req.icon_index;
    cache_size[target] = req.size_class;
    cache_stamp[target] = req.frame_number;
    cache_handle[target] = req.fill_handle;
    res.handle = req.fill_handle;
    res.slot = SLOT_W'(target);
    return res;
  endfunction

  function automatic lhc_in_t make_req(logic [ICON_W-1:0] icon, logic [SIZE_W-1:0] size,
                                       logic [STAMP_W-1:0] frame,
                                       logic [HANDLE_W-1:0] fill);
    lhc_in_t req;
    req.icon_index = icon;
    req.size_class = size;
    req.frame_number = frame;
    req.fill_handle = fill;
    return req;
  endfunction

  function automatic void add_lookup(logic [ICON_W-1:0] icon, logic [SIZE_W-1:0] size,
                                     logic [STAMP_W-1:0] frame, logic [HANDLE_W-1:0] fill);
    step_t row;
    row.is_cap = 1'b0;
    row.cap = '0;
    row.req = make_req(icon, size, frame, fill);
    row.known = 1'b0;
    row.want = '0;
    plan.insert(plan.size(), row);
  endfunction

  // A lookup whose answer is plain from the cache contents at that point.
  function automatic void add_known(logic [ICON_W-1:0] icon, logic [SIZE_W-1:0] size,
                                    logic [STAMP_W-1:0] frame, logic [HANDLE_W-1:0] fill,
                                    logic hit, logic [HANDLE_W-1:0] handle,
                                    logic [SLOT_W-1:0] slot, logic evicted);
    step_t row;
    row.is_cap = 1'b0;
    row.cap = '0;
    row.req = make_req(icon, size, frame, fill);
    row.known = 1'b1;
    row.want.hit = hit;
    row.want.handle = handle;
    row.want.slot = slot;
    row.want.evicted = evicted;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_cap(logic [CFG_W-1:0] value);
    step_t row;
    row.is_cap = 1'b1;
    row.cap = value;
    row.req = '0;
    row.known = 1'b0;
    row.want = '0;
    plan.insert(plan.size(), row);
  endfunction

  // Holds the sender back until every result owed has arrived. All the
  // tasks below are entered and left at a falling edge.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // The capacity register is only written with no lookup in flight.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    capacity_reg = value;
  endtask

  // Sends one lookup beat after a random gap and records what it must return.
  // Valid stays high after acceptance, so a back-to-back beat only swaps the
  // payload at the next falling edge.
  task automatic send_lookup(input lhc_in_t req, input bit known, input lhc_out_t want);
    int gap;
    lhc_out_t predicted;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    predicted = cache_lookup(req);
    expected_results.insert(expected_results.size(), known ? want : predicted);
    @(negedge clk);
  endtask

  // One stretch of random lookups under one capacity setting. Most lookups
  // reuse keys from a pool a little larger than the capacity, which keeps the
  // cache busy with hits, appends and evictions. The rest are fresh keys,
  // failed fills, jumps of the frame counter and the all-ones stamp.
  task automatic run_phase(input logic [CFG_W-1:0] cap, input int count, input int idle);
    int span;
    int roll;
    int k;
    lhc_in_t req;
    gap_max = idle;
    stall_max = idle;
    write_capacity(cap);
    span = effective_capacity() + effective_capacity() / 2 + 4;
    if (span > KEY_POOL) span = KEY_POOL;
    for (int n = 0; n < count; n++) begin
      // Halfway through, the sender lets the block run completely dry.
      if (n == count / 2) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        k = $urandom_range(0, span - 1);
        req.icon_index = pool_icon[k];
        req.size_class = pool_size[k];
      end else begin
        req.icon_index = $urandom;
        req.size_class = SIZE_W'($urandom_range(0, 7));
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        req.frame_number = $urandom;
      end else if (roll < 7) begin
        req.frame_number = '1;
      end else begin
        frame_now = frame_now + $urandom_range(0, 3);
        req.frame_number = frame_now;
      end
      if ($urandom_range(0, 9) == 0) begin
        req.fill_handle = '0;
      end else begin
        req.fill_handle = {$urandom, $urandom};
      end
      send_lookup(req, 1'b0, '0);
    end
  endtask

  // Drives out_stall for a random number of cycles, then takes one result
  // beat. The stall is drawn whether a result is waiting or not, so it lands
  // on every phase of the block's work.
  initial begin : receiver
    int stall_len;
    forever begin
      @(negedge clk);
      stall_len = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      if (stall_len > 0) begin
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                             input logic [HANDLE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    lhc_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no lookup outstanding: %p", out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, out_data.hit);
        check_field("handle", want.handle, out_data.handle);
        check_field("slot", want.slot, out_data.slot);
        check_field("evicted", want.evicted, out_data.evicted);
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_caps[RANDOM_PHASES];

    for (int i = 0; i < KEY_POOL; i++) begin
      pool_icon[i] = $urandom;
      pool_size[i] = SIZE_W'($urandom_range(0, 7));
    end
    frame_now = $urandom;

    // Directed table, starting from an empty cache with the capacity at 64.
    // A failed fill into the empty cache returns all zeros.
    add_known(32'h0000_1234, 3'd0, 32'd10, 64'd0, 1'b0, 64'd0, 6'd0, 1'b0);
    // The all-zero key and the all-ones key are appended in turn.
    add_known(32'h0, 3'd0, 32'd0, '1, 1'b0, '1, 6'd0, 1'b0);
    add_known('1, 3'd7, '1, 64'd1, 1'b0, 64'd1, 6'd1, 1'b0);
    // A hit returns the stored handle and ignores the fill handle.
    add_known(32'h0, 3'd0, 32'd20, 64'd0, 1'b1, '1, 6'd0, 1'b0);
    // Same icon with another size class is a different key.
    add_lookup(32'h0, 3'd7, 32'd21, 64'h5555_5555_5555_5555);
    add_lookup('1, 3'd7, 32'd22, 64'hAAAA_AAAA_AAAA_AAAA);
    add_known(32'h8000_0000, 3'd3, 32'd23, 64'd0, 1'b0, 64'd0, 6'd0, 1'b0);
    // Capacity dropped below the number of valid entries: nothing is lost,
    // and misses evict among all of them.
    add_cap(7'd1);
    add_lookup(32'hA5A5_A5A5, 3'd5, 32'd30, 64'h0123_4567_89AB_CDEF);
    add_lookup(32'h5A5A_5A5A, 3'd2, 32'd31, 64'hFEDC_BA98_7654_3210);
    // Zero capacity behaves as one entry.
    add_cap(7'd0);
    add_lookup(32'h0000_0001, 3'd1, 32'd32, 64'h8000_0000_0000_0000);
    add_lookup(32'hA5A5_A5A5, 3'd5, '1, 64'd0);
    // The largest register value behaves as the full cache, so misses append.
    add_cap(7'd127);
    add_lookup(32'h7FFF_FFFF, 3'd4, 32'd33, 64'h7FFF_FFFF_FFFF_FFFF);
    add_lookup(32'h00FF_00FF, 3'd6, 32'd34, 64'hFFFF_0000_FFFF_0000);
    // Bring every stamp to all ones; the next eviction must then pick entry 0.
    add_cap(7'd2);
    add_lookup(32'h5A5A_5A5A, 3'd2, '1, 64'd0);
    add_lookup(32'h0000_0001, 3'd1, '1, 64'd0);
    add_lookup(32'h7FFF_FFFF, 3'd4, '1, 64'd0);
    add_lookup(32'h00FF_00FF, 3'd6, '1, 64'd0);
    add_known(32'hDEAD_BEEF, 3'd0, '1, 64'd1, 1'b0, 64'd1, 6'd0, 1'b1);
    // A failed fill with the cache full still evicts nothing.
    add_known(32'hCAFE_F00D, 3'd3, 32'd0, 64'd0, 1'b0, 64'd0, 6'd0, 1'b0);
    add_cap(7'd64);

    // Random settings: small capacities first while few entries are valid,
    // then the large ones that let the cache fill all 64 entries.
    phase_caps[0] = 7'd3;
    phase_caps[1] = 7'd8;
    phase_caps[2] = 7'd1;
    phase_caps[3] = 7'd0;
    phase_caps[4] = 7'd16;
    phase_caps[5] = CFG_W'($urandom_range(0, 127));
    phase_caps[6] = 7'd127;
    phase_caps[7] = 7'd40;
    phase_caps[8] = 7'd64;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cap) begin
        write_capacity(plan[k].cap);
      end else begin
        send_lookup(plan[k].req, plan[k].known, plan[k].want);
      end
    end

    // Every third phase runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      run_phase(phase_caps[p], PHASE_ITEMS, (p % 3 == 1) ? 0 : 8);
    end

    wait_for_results();
    repeat (END_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
